// ===== design/hacl_pkg.sv =====
// Shared types, character constants, status codes and hex digit decode.
`timescale 1ns / 1ps

package hacl_pkg;

	// Result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_LEN   = 3'd1;
	localparam logic [2:0] ST_NOT_FRAME = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_SHORT     = 3'd4;

	// Characters of interest
	localparam logic [7:0] CH_S       = 8'h53;
	localparam logic [7:0] CH_C       = 8'h43;
	localparam logic [7:0] CH_A       = 8'h41;
	localparam logic [7:0] CH_N       = 8'h4E;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_UA      = 8'h41;
	localparam logic [7:0] CH_UF      = 8'h46;
	localparam logic [7:0] CH_LA      = 8'h61;
	localparam logic [7:0] CH_LF      = 8'h66;

	// Line layout
	localparam int unsigned HDR_LEN  = 12;
	localparam logic [7:0]  MAX_DLEN = 8'd8;

	// One result item
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  bus_id;
		logic [15:0] can_id;
		logic [7:0]  frame_length;
		logic [63:0] payload;
		logic        hex_error;
	} hacl_result_t;

	// Decode one hex character: {bad, nibble}; a non-hex character gives zero
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] d;
		logic [4:0] r;
		begin
			d = 8'd0;
			r = {1'b1, 4'd0};
			if (c >= CH_0 && c <= CH_9) begin
				d = c - CH_0;
				r = {1'b0, d[3:0]};
			end else if (c >= CH_UA && c <= CH_UF) begin
				d = c - CH_UA + 8'd10;
				r = {1'b0, d[3:0]};
			end else if (c >= CH_LA && c <= CH_LF) begin
				d = c - CH_LA + 8'd10;
				r = {1'b0, d[3:0]};
			end
			return r;
		end
	endfunction

endpackage

// ===== design/hacl_rx_if.sv =====
// Channel carrying received characters.
`timescale 1ns / 1ps

interface hacl_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/hacl_res_if.sv =====
// Channel carrying decoded line results.
`timescale 1ns / 1ps

interface hacl_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  bus_id;
	logic [15:0] can_id;
	logic [7:0]  frame_length;
	logic [63:0] payload;
	logic        hex_error;

	modport source (output valid, output status, output bus_id, output can_id,
		output frame_length, output payload, output hex_error, input ready);
	modport sink (input valid, input status, input bus_id, input can_id,
		input frame_length, input payload, input hex_error, output ready);
endinterface

// ===== design/hacl_line_decoder.sv =====
// Per-line state and incremental decode of header and data digits.
`timescale 1ns / 1ps

module hacl_line_decoder
	import hacl_pkg::*;
#(
	parameter int unsigned LINE_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [7:0]   ch,
	output logic         has_result,
	output hacl_result_t result
);

	localparam int unsigned PW = $clog2(LINE_DEPTH);

	logic [PW-1:0] pos_q;
	logic          prefix_ok_q;
	logic          hdr_bad_q;
	logic          data_bad_q;
	logic [7:0]    bus_q;
	logic [15:0]   id_q;
	logic [7:0]    len_q;
	logic [63:0]   payload_q;

	logic [4:0]    hx;
	logic [3:0]    nib;
	logic          bad;
	logic [9:0]    pw;
	logic          is_nl;
	logic          overflow;
	logic          pfx_match;
	logic          prefix_n;
	logic          in_hdr;
	logic [7:0]    bus_n;
	logic [15:0]   id_n;
	logic [7:0]    len_n;
	logic          hdr_bad_n;
	logic [9:0]    k;
	logic          in_data;
	logic [3:0]    nib_idx;
	logic [63:0]   payload_n;
	logic          len_bad;
	logic          short_line;

	// Decode the current character against the line position
	always_comb begin
		hx        = hex_nibble(ch);
		nib       = hx[3:0];
		bad       = hx[4];
		pw        = 10'(pos_q);
		is_nl     = (ch == CH_NEWLINE);
		overflow  = !is_nl && (pos_q == PW'(LINE_DEPTH - 1));

		case (pos_q[1:0])
			2'd0:    pfx_match = (ch == CH_S);
			2'd1:    pfx_match = (ch == CH_C);
			2'd2:    pfx_match = (ch == CH_A);
			2'd3:    pfx_match = (ch == CH_N);
			default: pfx_match = 1'b0;
		endcase
		prefix_n = prefix_ok_q & ((pw >= 10'd4) | pfx_match);

		in_hdr    = (pw >= 10'd4) && (pw < 10'(HDR_LEN));
		bus_n     = (pw == 10'd4 || pw == 10'd5) ? {bus_q[3:0], nib} : bus_q;
		id_n      = (pw >= 10'd6 && pw <= 10'd9) ? {id_q[11:0], nib} : id_q;
		len_n     = (pw == 10'd10 || pw == 10'd11) ? {len_q[3:0], nib} : len_q;
		hdr_bad_n = hdr_bad_q | (in_hdr & bad);

		// Data digit k of the line, within the announced length
		k       = pw - 10'(HDR_LEN);
		in_data = (pw >= 10'(HDR_LEN)) && (len_q != 8'd0) && (len_q <= MAX_DLEN)
			&& (k < {1'b0, len_q, 1'b0});
		nib_idx = {k[3:1], ~k[0]};
		payload_n = payload_q;
		if (in_data) begin
			payload_n[nib_idx*4 +: 4] = nib;
		end

		len_bad    = (len_n == 8'd0) || (len_n > MAX_DLEN);
		short_line = pw < ({1'b0, len_n, 1'b0} + 10'(HDR_LEN));
	end

	// Build the result for a newline or an overflow
	always_comb begin
		has_result = is_nl || overflow;
		result     = '0;
		if (overflow) begin
			result.status = ST_OVERFLOW;
		end else if (!prefix_n || pw < 10'(HDR_LEN - 1)) begin
			result.status = ST_NOT_FRAME;
		end else begin
			result.bus_id       = bus_n;
			result.can_id       = id_n;
			result.frame_length = len_n;
			result.hex_error    = hdr_bad_n;
			if (len_bad) begin
				result.status = ST_BAD_LEN;
			end else if (short_line) begin
				result.status = ST_SHORT;
			end else begin
				result.status    = ST_OK;
				result.payload   = payload_q;
				result.hex_error = hdr_bad_n | data_bad_q;
			end
		end
	end

	// Advance the line state; restart it at a line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			prefix_ok_q <= 1'b1;
			hdr_bad_q   <= 1'b0;
			data_bad_q  <= 1'b0;
			payload_q   <= '0;
		end else if (en) begin
			if (is_nl || overflow) begin
				pos_q       <= '0;
				prefix_ok_q <= 1'b1;
				hdr_bad_q   <= 1'b0;
				data_bad_q  <= 1'b0;
				payload_q   <= '0;
			end else begin
				pos_q       <= pos_q + PW'(1);
				prefix_ok_q <= prefix_n;
				hdr_bad_q   <= hdr_bad_n;
				data_bad_q  <= data_bad_q | (in_data & bad);
				payload_q   <= payload_n;
			end
		end
	end

	// Header fields are rewritten in every line that runs past the header
	always_ff @(posedge clk) begin
		if (en) begin
			bus_q <= bus_n;
			id_q  <= id_n;
			len_q <= len_n;
		end
	end

endmodule

// ===== design/hacl_out_reg.sv =====
// Result register that holds one result until the sink takes it.
`timescale 1ns / 1ps

module hacl_out_reg
	import hacl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  hacl_result_t din,
	output logic         free,
	hacl_res_if.source   res
);

	logic         valid_q;
	hacl_result_t data_q;

	// Slot can take a new result when empty or emptied in this cycle
	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= din;
		end
	end

	assign res.valid        = valid_q;
	assign res.status       = data_q.status;
	assign res.bus_id       = data_q.bus_id;
	assign res.can_id       = data_q.can_id;
	assign res.frame_length = data_q.frame_length;
	assign res.payload      = data_q.payload;
	assign res.hex_error    = data_q.hex_error;

endmodule

// ===== design/hex_ascii_can_line_parser.sv =====
// Top level: input register, line decoder and result register.
// A line-ending character held in the input register is decoded combinationally, and its
//   result loads into the result register once that register is free to take it.
// Throughput: one character per cycle while the result register can take each result; the
//   decode of each character is a single pass between the input register and the result register.
// Reset: arst_n clears both valid flags and restarts the current line.
`timescale 1ns / 1ps

module hex_ascii_can_line_parser
	import hacl_pkg::*;
#(
	parameter int unsigned LINE_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	hacl_rx_if.sink    rx,
	hacl_res_if.source res
);

	logic         ch_valid_s1;
	logic [7:0]   ch_s1;
	logic         proc_en;
	logic         has_result;
	logic         out_free;
	hacl_result_t result;

	// Process the held character unless its result has nowhere to go
	assign proc_en  = ch_valid_s1 && (out_free || !has_result);
	assign rx.ready = !ch_valid_s1 || proc_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			ch_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			ch_s1 <= rx.rx_byte;
		end
	end

	hacl_line_decoder #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (proc_en),
		.ch         (ch_s1),
		.has_result (has_result),
		.result     (result)
	);

	hacl_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (proc_en && has_result),
		.din    (result),
		.free   (out_free),
		.res    (res)
	);

endmodule

// ===== tb/testbench.sv =====
// Testbench for the hex ASCII CAN line parser: random lines checked against a predictor.
`timescale 1ns / 1ps

module testbench;
	import hacl_pkg::*;

	localparam int LINE_DEPTH   = 64;
	localparam int RANDOM_CHARS = 1000;
	localparam int MIN_LINES    = 48;
	localparam int HOLD_AFTER   = 700;
	localparam int HOLD_CYCLES  = 400;

	logic clk;
	logic arst_n;

	hacl_rx_if  rx_ch ();
	hacl_res_if res_ch ();

	hex_ascii_can_line_parser #(.LINE_DEPTH(LINE_DEPTH)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.res   (res_ch)
	);

	// Predicted line state
	logic [7:0]   line_buf [0:LINE_DEPTH-1];
	int           line_fill;

	// Characters waiting to be sent and frames waiting to come out
	logic [7:0]   chars_pending [$];
	hacl_result_t frames_due [$];
	hacl_result_t due;
	hacl_result_t want;

	int           mismatches;
	int           lines_queued;
	int           chars_taken;
	int           burst_left;
	int           gap_left;
	int           hold_left;
	bit           hold_done;
	logic [15:0]  ready_pat;
	int           pat_phase;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] exp_val);
		$display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, exp_val);
		mismatches++;
	endtask

	// Decode a run of hex digits from the predicted line; non-hex reads as zero
	function automatic logic [15:0] hex_value(input int pos, input int digits, inout bit bad);
		logic [15:0] v;
		logic [7:0]  c;
		logic [3:0]  nib;
		v = '0;
		for (int k = 0; k < digits; k++) begin
			c = line_buf[(pos + k) % LINE_DEPTH];
			if (c >= CH_0 && c <= CH_9) begin
				nib = c[3:0];
			end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
				nib = c[3:0] + 4'd9;
			end else begin
				nib = 4'd0;
				bad = 1'b1;
			end
			v = {v[11:0], nib};
		end
		return v;
	endfunction

	// Advance the predicted line by one character; return 1 when a frame result is due
	function automatic bit parse_char(input logic [7:0] c, output hacl_result_t r);
		bit         bad;
		logic [15:0] f;
		logic [7:0] len_code;
		r = '0;
		bad = 1'b0;
		if (line_fill >= LINE_DEPTH)
			line_fill = 0;
		line_buf[line_fill] = c;
		line_fill++;
		if (c == CH_NEWLINE) begin
			if (line_fill < HDR_LEN || line_buf[0] != CH_S || line_buf[1] != CH_C ||
				line_buf[2] != CH_A || line_buf[3] != CH_N) begin
				r.status = ST_NOT_FRAME;
			end else begin
				f = hex_value(4, 2, bad);
				r.bus_id = f[7:0];
				r.can_id = hex_value(6, 4, bad);
				f = hex_value(10, 2, bad);
				len_code = f[7:0];
				r.frame_length = len_code;
				if (len_code == 8'd0 || len_code > MAX_DLEN) begin
					r.status = ST_BAD_LEN;
				end else if (line_fill < HDR_LEN + 1 + 2 * int'(len_code)) begin
					r.status = ST_SHORT;
				end else begin
					for (int i = 0; i < int'(len_code); i++) begin
						f = hex_value(HDR_LEN + 2 * i, 2, bad);
						r.payload[8*i +: 8] = f[7:0];
					end
					r.status = ST_OK;
				end
				r.hex_error = bad;
			end
			line_fill = 0;
			return 1'b1;
		end
		if (line_fill >= LINE_DEPTH) begin
			line_fill = 0;
			r.status = ST_OVERFLOW;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Stimulus helpers
	task automatic push_char(input logic [7:0] c);
		chars_pending.push_back(c);
		if (c == CH_NEWLINE)
			lines_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	function automatic logic [7:0] any_but_newline();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (c == CH_NEWLINE)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return CH_0 + 8'(v);
		return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v) - 8'd10;
	endfunction

	task automatic push_hex(inout logic [7:0] body [$], input logic [15:0] v, input int digits);
		for (int k = digits - 1; k >= 0; k--)
			body.push_back(hex_char(v[4*k +: 4]));
	endtask

	// Queue one random line, mostly well-formed frames with random content
	task automatic queue_random_line();
		logic [7:0] body [$];
		int         kind;
		int         len_code;
		int         digits;
		kind = $urandom_range(0, 99);
		body = {CH_S, CH_C, CH_A, CH_N};
		push_hex(body, 16'($urandom_range(0, 255)), 2);
		push_hex(body, 16'($urandom_range(0, 65535)), 4);
		if (kind < 65) begin
			len_code = $urandom_range(1, 8);
			digits = 2 * len_code;
		end else begin
			len_code = $urandom_range(0, 1) ? 0 : $urandom_range(9, 255);
			digits = $urandom_range(0, 6);
		end
		push_hex(body, 16'(len_code), 2);
		// cut the data short of what the length asks
		if (kind >= 55 && kind < 65)
			digits = $urandom_range(0, 2 * len_code - 1);
		for (int i = 0; i < digits; i++)
			body.push_back(hex_char(4'($urandom_range(0, 15))));
		if (kind < 55 && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 5)) body.push_back(any_but_newline());
		// break the prefix
		if (kind >= 65 && kind < 75)
			body[$urandom_range(0, 3)] = any_but_newline();
		// drop in a character that is probably not hex
		if (kind < 75 && $urandom_range(0, 7) == 0)
			body[$urandom_range(4, body.size() - 1)] = any_but_newline();
		if (kind >= 75 && kind < 90) begin
			body.delete();
			repeat ($urandom_range(0, 20)) body.push_back(8'($urandom_range(0, 255)));
		end else if (kind >= 90 && kind < 95) begin
			// run past the store without a newline
			body.delete();
			repeat ($urandom_range(LINE_DEPTH, LINE_DEPTH + 36))
				body.push_back(any_but_newline());
			lines_queued++;
		end else if (kind >= 95) begin
			// pad so the newline lands on the last slot of the store
			while (body.size() < LINE_DEPTH - 1)
				body.push_back(any_but_newline());
		end
		foreach (body[i])
			push_char(body[i]);
		push_char(CH_NEWLINE);
	endtask

	// Drive characters in bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid   <= 1'b0;
			rx_ch.rx_byte <= 8'd0;
			burst_left = 0;
			gap_left = 0;
			line_fill = 0;
		end else begin
			// predict on each transfer taken
			if (rx_ch.valid && rx_ch.ready) begin
				if (parse_char(rx_ch.rx_byte, due))
					frames_due.push_back(due);
				chars_taken <= chars_taken + 1;
			end
			if (!(rx_ch.valid && !rx_ch.ready)) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
				if (burst_left > 0 && chars_pending.size() > 0) begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= chars_pending.pop_front();
					burst_left--;
				end else begin
					rx_ch.valid <= 1'b0;
					if (burst_left == 0)
						gap_left--;
				end
			end
		end
	end

	// Stall the result side on a changing pattern, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
			pat_phase = 0;
			ready_pat = '1;
		end else begin
			if (!hold_done && chars_taken >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				if (pat_phase == 0) begin
					case ($urandom_range(0, 3))
						0: ready_pat = '1;
						1: ready_pat = 16'($urandom);
						2: ready_pat = 16'($urandom) & 16'($urandom);
						default: ready_pat = 16'($urandom) | 16'($urandom);
					endcase
				end
				res_ch.ready <= ready_pat[pat_phase];
				pat_phase = (pat_phase + 1) % 16;
			end
		end
	end

	// Check each result transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (frames_due.size() == 0) begin
				flag_mismatch("unexpected result, status", 64'(res_ch.status), 64'd0);
			end else begin
				want = frames_due.pop_front();
				if (res_ch.status !== want.status)
					flag_mismatch("status", 64'(res_ch.status), 64'(want.status));
				if (res_ch.bus_id !== want.bus_id)
					flag_mismatch("bus_id", 64'(res_ch.bus_id), 64'(want.bus_id));
				if (res_ch.can_id !== want.can_id)
					flag_mismatch("can_id", 64'(res_ch.can_id), 64'(want.can_id));
				if (res_ch.frame_length !== want.frame_length)
					flag_mismatch("frame_length", 64'(res_ch.frame_length),
						64'(want.frame_length));
				if (res_ch.payload !== want.payload)
					flag_mismatch("payload", res_ch.payload, want.payload);
				if (res_ch.hex_error !== want.hex_error)
					flag_mismatch("hex_error", 64'(res_ch.hex_error), 64'(want.hex_error));
			end
		end
	end

	// Build the stimulus, reset, and wait for the last frame
	initial begin
		int random_start;
		mismatches = 0;
		lines_queued = 0;
		chars_taken = 0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'd0;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;

		// full frame, mixed-case digits
		push_text("SCAN01ABCD080123456789abcdef\n");
		// bus and id all ones, single byte
		push_text("SCANFFffff01A5\n");
		// length zero and length far too big
		push_text("SCAN00000000\n");
		push_text("SCAN123456FF\n");
		// header that runs into the newline
		push_text("SCAN0112340\n");
		// data stops before the length is met
		push_text("SCAN01123403AABB\n");
		// non-hex digits in header and data
		push_text("SCAN0G1234021z34\n");
		// not a frame: wrong prefix, too short, empty
		push_text("SCAM01123401AA\n");
		push_text("SCAN\n");
		push_text("\n");
		push_char(8'h00);
		push_char(8'hFF);
		push_text("\n");
		// overflow, then a frame whose newline fills the store exactly
		repeat (LINE_DEPTH) push_char("x");
		lines_queued++;
		push_text("SCAN01123401AB");
		repeat (LINE_DEPTH - 15) push_char("z");
		push_text("\n");

		random_start = chars_pending.size();
		while (chars_pending.size() - random_start < RANDOM_CHARS || lines_queued < MIN_LINES)
			queue_random_line();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (chars_pending.size() != 0 || rx_ch.valid)
			@(posedge clk);
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/hacl_pkg.sv
design/hacl_rx_if.sv
design/hacl_res_if.sv
design/hacl_line_decoder.sv
design/hacl_out_reg.sv
design/hex_ascii_can_line_parser.sv
tb/testbench.sv
